[design/r2fft_pkg.sv]
// Shared types and constants for the radix-2 FFT.
package r2fft_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned DataWidth   = 22;
  localparam int unsigned CoefWidth   = 17;
  localparam int unsigned MaxAddrBits = 6;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [DataWidth-1:0]   data_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMul,
    StSum,
    StWrite,
    StEmit
  } fft_state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic sum;
    logic wr;
    logic emit_rd;
  } fft_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic bfly_last;
    logic emit_last;
    logic emit_free;
  } fft_status_t;

  localparam logic signed [CoefWidth-1:0] QuarterCos [17] = '{
    17'sd32767, 17'sd32609, 17'sd32137, 17'sd31356, 17'sd30273, 17'sd28898,
    17'sd27245, 17'sd25329, 17'sd23170, 17'sd20787, 17'sd18204, 17'sd15446,
    17'sd12539, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0
  };

  function automatic coef_t tw_cos(input logic [4:0] j);
    if (j <= 5'd16) return QuarterCos[j];
    return -QuarterCos[5'(6'd32 - {1'b0, j})];
  endfunction

  function automatic coef_t tw_sin(input logic [4:0] j);
    if (j <= 5'd16) return QuarterCos[5'd16 - j];
    return QuarterCos[j - 5'd16];
  endfunction

  function automatic data_t sat22(input logic signed [DataWidth+1:0] v);
    if (v > 24'sd2097151) return 22'sd2097151;
    if (v < -24'sd2097152) return -22'sd2097152;
    return v[DataWidth-1:0];
  endfunction

endpackage

[design/r2fft_if.sv]
// Valid/ready channel interfaces for samples and spectrum bins.
interface r2fft_in_if import r2fft_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_re;
  sample_t in_im;
  modport source (output valid, in_re, in_im, input ready);
  modport sink (input valid, in_re, in_im, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  data_t                  out_re;
  data_t                  out_im;
  logic [MaxAddrBits-1:0] bin_index;
  logic                   last_bin;
  modport source (output valid, out_re, out_im, bin_index, last_bin, input ready);
  modport sink (input valid, out_re, out_im, bin_index, last_bin, output ready);
endinterface

[design/r2fft_ctrl.sv]
// Frame sequencer: load, butterfly passes, emission.
module r2fft_ctrl import r2fft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  fft_status_t status_i,
  output fft_cmd_t    cmd_o,
  output logic        in_ready_o,
  output logic        busy_o
);

  fft_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && status_i.frame_full) state_d = StRead;
      end
      StRead:  state_d = StMul;
      StMul:   state_d = StSum;
      StSum:   state_d = StWrite;
      StWrite: state_d = status_i.bfly_last ? StEmit : StRead;
      StEmit: begin
        if (status_i.emit_last && status_i.emit_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    busy_o     = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        busy_o     = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StRead:  cmd_o.rd  = 1'b1;
      StMul:   cmd_o.mul = 1'b1;
      StSum:   cmd_o.sum = 1'b1;
      StWrite: cmd_o.wr  = 1'b1;
      StEmit:  cmd_o.emit_rd = status_i.emit_free;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

[design/r2fft_datapath.sv]
// Working stores, butterfly unit, and output register.
module r2fft_datapath import r2fft_pkg::*; #(
  parameter int unsigned Bits = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fft_cmd_t           cmd_i,
  input  logic               in_ready_i,
  output fft_status_t        status_o,
  r2fft_in_if.sink           in_ch,
  r2fft_out_if.source        out_ch
);

  localparam int unsigned Points = 1 << Bits;
  localparam int unsigned StgW = (Bits > 1) ? $clog2(Bits) : 1;
  localparam int unsigned BfW  = (Bits > 1) ? Bits - 1 : 1;

  data_t mem_re [Points];
  data_t mem_im [Points];

  logic [Bits-1:0] load_cnt_q;
  logic [StgW-1:0] stage_q;
  logic [BfW-1:0]  bf_q;
  logic [Bits-1:0] emit_cnt_q;

  logic [Bits-1:0] rev;
  always_comb begin
    for (int i = 0; i < Bits; i++) rev[i] = load_cnt_q[Bits-1-i];
  end

  // butterfly addressing: insert 0 at bit position stage
  logic [Bits-1:0] half, addr_a, addr_b, low_mask;
  logic [Bits-1:0] bf_w, mm;
  logic [4:0]      tw_j;
  always_comb begin
    bf_w     = Bits'(bf_q);
    half     = Bits'(1) << stage_q;
    low_mask = half - Bits'(1);
    mm       = bf_w & low_mask;
    addr_a   = ((bf_w & ~low_mask) << 1) | mm;
    addr_b   = addr_a | half;
    tw_j     = 5'((mm << (MaxAddrBits - 1 - stage_q)) & 6'h1f);
  end

  data_t ar_q, ai_q, br_q, bi_q;
  coef_t wr_q, wi_q;
  logic signed [DataWidth+CoefWidth-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DataWidth+1:0] tr_q, ti_q;
  logic [Bits-1:0] a_q, b_q;

  function automatic logic signed [DataWidth+1:0] rnd(
    input logic signed [DataWidth+CoefWidth-1:0] p);
    logic signed [DataWidth+CoefWidth-1:0] v;
    v = (p + 39'sd16384) >>> 15;
    return v[DataWidth+1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_re[rev] <= DataWidth'(in_ch.in_re);
      mem_im[rev] <= DataWidth'(in_ch.in_im);
    end
    if (cmd_i.rd) begin
      ar_q <= mem_re[addr_a];
      ai_q <= mem_im[addr_a];
      br_q <= mem_re[addr_b];
      bi_q <= mem_im[addr_b];
      a_q  <= addr_a;
      b_q  <= addr_b;
      wr_q <= tw_cos(tw_j);
      wi_q <= -tw_sin(tw_j);
    end
    if (cmd_i.mul) begin
      p_rr_q <= br_q * wr_q;
      p_ii_q <= bi_q * wi_q;
      p_ri_q <= br_q * wi_q;
      p_ir_q <= bi_q * wr_q;
    end
    if (cmd_i.sum) begin
      tr_q <= rnd(p_rr_q) - rnd(p_ii_q);
      ti_q <= rnd(p_ri_q) + rnd(p_ir_q);
    end
    if (cmd_i.wr) begin
      mem_re[a_q] <= sat22((DataWidth+2)'(ar_q) + tr_q);
      mem_im[a_q] <= sat22((DataWidth+2)'(ai_q) + ti_q);
      mem_re[b_q] <= sat22((DataWidth+2)'(ar_q) - tr_q);
      mem_im[b_q] <= sat22((DataWidth+2)'(ai_q) - ti_q);
    end
    if (cmd_i.emit_rd) begin
      out_ch.out_re    <= mem_re[emit_cnt_q];
      out_ch.out_im    <= mem_im[emit_cnt_q];
      out_ch.bin_index <= MaxAddrBits'(emit_cnt_q);
      out_ch.last_bin  <= (emit_cnt_q == Bits'(Points - 1));
    end
  end

  logic bf_end, stage_end;
  assign bf_end    = (bf_q == BfW'(Points / 2 - 1));
  assign stage_end = (stage_q == StgW'(Bits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q   <= '0;
      stage_q      <= '0;
      bf_q         <= '0;
      emit_cnt_q   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cmd_i.load) load_cnt_q <= load_cnt_q + Bits'(1);
      if (cmd_i.wr) begin
        bf_q <= bf_end ? '0 : bf_q + BfW'(1);
        if (bf_end) stage_q <= stage_end ? '0 : stage_q + StgW'(1);
      end
      if (cmd_i.emit_rd) begin
        emit_cnt_q   <= emit_cnt_q + Bits'(1);
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  assign status_o.frame_full = (load_cnt_q == Bits'(Points - 1));
  assign status_o.bfly_last  = bf_end && stage_end;
  assign status_o.emit_last  = (emit_cnt_q == Bits'(Points - 1));
  assign status_o.emit_free  = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = in_ready_i;

endmodule

[design/radix2_fft.sv]
// Top level of the radix-2 FFT.
// Load: one sample per cycle while idle and the source is valid, Points per frame.
// Transform: Points/2*Bits butterflies, done one at a time by the single
// shared butterfly unit in its read-multiply-sum-write loop.
// Emission: one bin per cycle while the sink is ready.
// Reset clears the sequencer and counters; the working stores are not cleared.
module radix2_fft import r2fft_pkg::*; #(
  parameter int unsigned POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  r2fft_in_if.sink    in_ch,
  r2fft_out_if.source out_ch
);

  localparam int unsigned Pc   = (POINTS < 2) ? 2 : ((POINTS > 64) ? 64 : POINTS);
  localparam int unsigned Bits = $clog2(Pc + 1) - 1;

  fft_cmd_t    cmd;
  fft_status_t status;
  logic        in_ready, busy;

  r2fft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready),
    .busy_o     (busy)
  );

  r2fft_datapath #(.Bits(Bits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .in_ready_i (in_ready),
    .status_o   (status),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("bin dropped");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.rd, cmd.mul, cmd.sum, cmd.wr, cmd.emit_rd}))
    else $error("conflicting commands");

endmodule
